@@ rtl/ncs_pkg.sv @@
// Shared types and codes for the nested comment scanner.
// No dependencies; imported by the scanner top level and the testbench.
package ncs_pkg;

  typedef logic [20:0] char_t;
  typedef logic [2:0]  status_t;
  typedef logic [2:0]  phase_t;

  // Result status codes
  localparam status_t ST_SKIP     = 3'd0;
  localparam status_t ST_MORE     = 3'd1;
  localparam status_t ST_CLOSED   = 3'd2;
  localparam status_t ST_REJECT   = 3'd3;
  localparam status_t ST_UNCLOSED = 3'd4;

  // Scanner phases
  localparam phase_t PH_START = 3'd0;
  localparam phase_t PH_OPEN  = 3'd1;
  localparam phase_t PH_BODY  = 3'd2;
  localparam phase_t PH_PAREN = 3'd3;
  localparam phase_t PH_STAR  = 3'd4;

  // Character codes
  localparam char_t CH_LPAREN = 21'h28;
  localparam char_t CH_RPAREN = 21'h29;
  localparam char_t CH_STAR   = 21'h2A;
  localparam char_t CH_SPACE  = 21'h20;
  localparam char_t CH_TAB    = 21'h09;
  localparam char_t CH_CR     = 21'h0D;

  localparam int NEST_W = 16;

endpackage

@@ rtl/nested_comment_scanner.sv @@
// Nested block comment scanner: one character request in, one status result out.
// Depends on ncs_pkg for status, phase and character codes.

// Accepts one character request every cycle unless in_stall is high and returns one
// result per request through an input register and then a result register. The scan
// state and the nesting depth counter are updated as a request moves between those
// registers, so consecutive characters stream without gaps when nothing stalls. Leading ASCII
// whitespace is skipped, "(*" opens a comment, nested "(*" and "*)" pairs move the
// depth (saturating at 2^DEPTH_BITS - 1), and a return to depth zero closes it.
// end_of_input inside a comment reports it unclosed. nest_depth shows the low
// 16 bits of the depth counter, or zero on a reject.
module nested_comment_scanner #(
  parameter int DEPTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ncs_pkg::char_t    char_code,
  input  logic              end_of_input,
  input  logic              comment_wanted,
  output logic              out_valid,
  input  logic              out_stall,
  output ncs_pkg::status_t  status,
  output logic [15:0]       nest_depth
);
  import ncs_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  // Input register
  logic              s1_valid;
  char_t             s1_char;
  logic              s1_eoi;
  logic              s1_wanted;

  // Scan state
  phase_t            phase, phase_next;
  logic [DEPTH_BITS-1:0] depth, depth_next;

  logic              out_ready;
  logic              s1_fire;
  status_t           status_next;
  logic [DEPTH_BITS-1:0] shown;
  logic [DEPTH_BITS+NEST_W-1:0] shown_ext;
  logic              is_space;

  assign out_ready = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_char   <= char_code;
      s1_eoi    <= end_of_input;
      s1_wanted <= comment_wanted;
    end
  end

  assign is_space = (s1_char == CH_SPACE) || (s1_char >= CH_TAB && s1_char <= CH_CR);

  always_comb begin
    phase_next  = phase;
    depth_next  = depth;
    status_next = ST_MORE;
    unique case (phase)
      PH_START: begin
        if (!s1_wanted || s1_eoi) begin
          status_next = ST_REJECT;
        end else if (is_space) begin
          status_next = ST_SKIP;
        end else if (s1_char == CH_LPAREN) begin
          phase_next = PH_OPEN;
        end else begin
          status_next = ST_REJECT;
        end
      end
      PH_OPEN: begin
        if (!s1_eoi && s1_char == CH_STAR) begin
          depth_next = DEPTH_ONE;
          phase_next = PH_BODY;
        end else begin
          status_next = ST_REJECT;
        end
      end
      PH_BODY, PH_PAREN, PH_STAR: begin
        priority if (s1_eoi) begin
          status_next = ST_UNCLOSED;
        end else if (phase == PH_PAREN && s1_char == CH_STAR) begin
          if (depth != DEPTH_MAX) depth_next = depth + DEPTH_ONE;
          phase_next = PH_BODY;
        end else if (phase == PH_STAR && s1_char == CH_RPAREN) begin
          if (depth != '0) depth_next = depth - DEPTH_ONE;
          phase_next = PH_BODY;
          status_next = (depth_next == '0) ? ST_CLOSED : ST_MORE;
        end else if (s1_char == CH_LPAREN) begin
          phase_next = PH_PAREN;
        end else if (s1_char == CH_STAR) begin
          phase_next = PH_STAR;
        end else begin
          phase_next = PH_BODY;
        end
      end
      default: status_next = ST_REJECT;
    endcase

    shown = (status_next == ST_REJECT) ? '0 : depth_next;

    // drop back to start after any end or reject
    if (status_next == ST_REJECT || status_next == ST_CLOSED ||
        status_next == ST_UNCLOSED) begin
      phase_next = PH_START;
      depth_next = '0;
    end
  end

  assign shown_ext = {{NEST_W{1'b0}}, shown};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        phase <= phase_next;
        depth <= depth_next;
      end
      if (out_ready) out_valid <= s1_valid;
    end
    if (s1_fire) begin
      status     <= status_next;
      nest_depth <= shown_ext[NEST_W-1:0];
    end
  end

  a_closed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CLOSED |-> nest_depth == '0)
    else $error("closed comment reports nonzero depth");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SKIP |-> nest_depth == '0)
    else $error("whitespace skip reports nonzero depth");

  a_reject_start: assert property (@(posedge clk) disable iff (rst)
    s1_fire && status_next == ST_REJECT |=> phase == PH_START && depth == '0)
    else $error("reject did not return to start");

  a_depth_in_body: assert property (@(posedge clk) disable iff (rst)
    depth != '0 |-> (phase == PH_BODY || phase == PH_PAREN || phase == PH_STAR))
    else $error("nonzero depth outside comment body");

endmodule

@@ tb/nested_comment_scanner_tb.sv @@
// Testbench for nested_comment_scanner: character requests in, status and depth out.
// Depends on ncs_pkg and the scanner RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module nested_comment_scanner_tb;
  import ncs_pkg::*;

  localparam char_t CH_NUL    = 21'h0;
  localparam char_t CH_LETTER = 21'h61;
  localparam char_t CODE_MAX  = 21'h10FFFF;
  localparam logic [15:0] DEPTH_TOP = 16'hFFFF;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int DEEP_PAIRS = 100;

  typedef struct packed {
    status_t     status;
    logic [15:0] depth;
  } scan_result_t;

  class comment_scoreboard;
    phase_t       scan_phase;
    logic [15:0]  depth;
    scan_result_t expected_results[$];
    int           mismatches;

    function new();
      scan_phase = PH_START;
      depth = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the predicted scan state by one accepted request.
    function void note_request(char_t c, logic eoi, logic wanted);
      status_t      st;
      scan_result_t res;
      logic         blank;
      blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      case (scan_phase)
        PH_START: begin
          if (!wanted || eoi) st = ST_REJECT;
          else if (blank) st = ST_SKIP;
          else if (c == CH_LPAREN) begin
            scan_phase = PH_OPEN;
            st = ST_MORE;
          end else st = ST_REJECT;
        end
        PH_OPEN: begin
          if (!eoi && c == CH_STAR) begin
            depth = 16'd1;
            scan_phase = PH_BODY;
            st = ST_MORE;
          end else begin
            scan_phase = PH_START;
            depth = '0;
            st = ST_REJECT;
          end
        end
        PH_BODY, PH_PAREN, PH_STAR: begin
          if (eoi) st = ST_UNCLOSED;
          else if (scan_phase == PH_PAREN && c == CH_STAR) begin
            if (depth != DEPTH_TOP) depth = depth + 16'd1;
            scan_phase = PH_BODY;
            st = ST_MORE;
          end else if (scan_phase == PH_STAR && c == CH_RPAREN) begin
            if (depth != '0) depth = depth - 16'd1;
            scan_phase = PH_BODY;
            st = (depth == '0) ? ST_CLOSED : ST_MORE;
          end else begin
            // an unmatched half pair falls through as ordinary text
            if (c == CH_LPAREN) scan_phase = PH_PAREN;
            else if (c == CH_STAR) scan_phase = PH_STAR;
            else scan_phase = PH_BODY;
            st = ST_MORE;
          end
        end
        default: begin
          scan_phase = PH_START;
          depth = '0;
          st = ST_REJECT;
        end
      endcase
      res.status = st;
      res.depth = depth;
      if (st == ST_CLOSED || st == ST_UNCLOSED) begin
        scan_phase = PH_START;
        depth = '0;
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(status_t got_status, logic [15:0] got_depth);
      scan_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d depth %0d",
                 $time, got_status, got_depth);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got_status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
        mismatches++;
      end
      if (got_depth !== want.depth) begin
        $display("%0t: nest_depth expected %0d actual %0d", $time, want.depth, got_depth);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  char_t       char_code;
  logic        end_of_input;
  logic        comment_wanted;
  logic        out_valid;
  logic        out_stall;
  status_t     status;
  logic [15:0] nest_depth;

  comment_scoreboard sb = new();
  bit pace_gaps = 1'b1;
  int requests_sent = 0;

  nested_comment_scanner u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .end_of_input   (end_of_input),
    .comment_wanted (comment_wanted),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .nest_depth     (nest_depth)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic char_t any_code();
    case ($urandom_range(0, 7))
      0: return char_t'($urandom_range(0, CODE_MAX));
      1: return CH_NUL;
      2: return ($urandom_range(0, 5) == 0) ? CH_SPACE : char_t'($urandom_range(CH_TAB, CH_CR));
      3: return char_t'($urandom_range(21'h100000, CODE_MAX));
      default: return char_t'($urandom_range(33, 126));
    endcase
  endfunction

  // Bias toward the pair characters so nesting rises and falls.
  function automatic char_t body_code();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return CH_LPAREN;
      5, 6, 7, 8, 9: return CH_STAR;
      10, 11, 12, 13: return CH_RPAREN;
      default: return any_code();
    endcase
  endfunction

  function automatic char_t blank_code();
    return ($urandom_range(0, 5) == 0) ? CH_SPACE : char_t'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // Hold the request until accepted; with no gap drawn, valid stays high so back-to-back requests stream.
  task automatic send_request(input char_t c, input logic eoi, input logic wanted);
    int gap;
    gap = pace_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_input <= eoi;
    comment_wanted <= wanted;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c, eoi, wanted);
    requests_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side: take a result, then stall for a random stretch, which may be empty.
  initial begin
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(status, nest_depth);
        hold = pace_gaps ? $urandom_range(0, 17) : 0;
        if (hold > 0) out_stall <= 1'b1;
      end else if (out_stall) begin
        hold--;
        if (hold <= 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    char_t code;
    int    base;
    int    len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    char_code <= '0;
    end_of_input <= 1'b0;
    comment_wanted <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: start-phase rejects and whitespace
    send_request(CH_LPAREN, 1'b0, 1'b0);
    send_request(CH_LETTER, 1'b1, 1'b1);
    for (code = CH_TAB; code <= CH_CR; code++) send_request(code, 1'b0, 1'b1);
    send_request(CH_SPACE, 1'b0, 1'b1);
    send_request(CH_NUL, 1'b0, 1'b1);
    send_request(CH_LETTER, 1'b0, 1'b1);
    // bad openers
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_LETTER, 1'b0, 1'b1);
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_NUL, 1'b1, 1'b1);
    // nested comment with pending pairs that fall through, then closed
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_NUL, 1'b0, 1'b1);
    send_request(CODE_MAX, 1'b0, 1'b0);
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_LETTER, 1'b0, 1'b1);
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b0);
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_RPAREN, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_LETTER, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_RPAREN, 1'b0, 1'b1);
    // unclosed at end of input
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_LETTER, 1'b1, 1'b0);
    wait_drain();

    // drive the depth deep at full rate, back off, end unclosed
    pace_gaps = 1'b0;
    send_request(CH_LPAREN, 1'b0, 1'b1);
    send_request(CH_STAR, 1'b0, 1'b1);
    repeat (DEEP_PAIRS) begin
      send_request(CH_LPAREN, 1'b0, 1'b1);
      send_request(CH_STAR, 1'b0, 1'b1);
    end
    send_request(CH_STAR, 1'b0, 1'b1);
    send_request(CH_RPAREN, 1'b0, 1'b1);
    send_request(CH_NUL, 1'b1, 1'b1);
    wait_drain();

    // random: mostly well-formed comments with random bodies, some noise
    base = requests_sent;
    while (requests_sent - base < RANDOM_REQUESTS) begin
      pace_gaps = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6))
          send_request(any_code(), $urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
      end else begin
        repeat ($urandom_range(0, 3)) send_request(blank_code(), 1'b0, 1'b1);
        send_request(CH_LPAREN, 1'b0, 1'b1);
        if ($urandom_range(0, 9) == 0) begin
          send_request(any_code(), $urandom_range(0, 3) == 0, 1'b1);
        end else begin
          send_request(CH_STAR, 1'b0, 1'b1);
          len = $urandom_range(0, 60);
          while (len > 0 && sb.scan_phase != PH_START) begin
            send_request(body_code(), 1'b0, $urandom_range(0, 1) == 1);
            len--;
          end
          if (sb.scan_phase != PH_START && $urandom_range(0, 1) == 1)
            send_request(any_code(), 1'b1, $urandom_range(0, 1) == 1);
        end
      end
      if ($urandom_range(0, 39) == 0) wait_drain();
    end

    wait_drain();
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ncs_pkg.sv
rtl/nested_comment_scanner.sv
tb/nested_comment_scanner_tb.sv
